[rtl/core/gcee_pkg.sv]
// Package for the gamepad change event encoder: widths, register indexes,
// controller/datapath interface structs and the combo remap function.
// No dependencies.
`default_nettype none

package gcee_pkg;

    localparam int BUTTONS_PER_PAD = 12;
    localparam int PADS            = 2;
    localparam int SCAN_LEN        = BUTTONS_PER_PAD * PADS;
    localparam int IDX_W           = $clog2(SCAN_LEN);
    localparam int SAMPLE_W        = 32;
    localparam int BUTTON_W        = 4;
    localparam int COMBO_W         = 8;
    localparam int PRESENT_W       = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_COMBO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_PRESENT = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } gcee_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_events;
        logic rest_empty;
        logic out_free;
    } gcee_sts_t;

    // One-hot held-combo bit for a pad-0 button; the d-pad maps to nothing.
    function automatic logic [COMBO_W-1:0] combo_mask(input logic [BUTTON_W-1:0] b);
        logic [COMBO_W-1:0] m;
        begin
            case (b)
                4'd0:    m = 8'h08;
                4'd1:    m = 8'h20;
                4'd2:    m = 8'h40;
                4'd3:    m = 8'h80;
                4'd8:    m = 8'h04;
                4'd9:    m = 8'h10;
                4'd10:   m = 8'h01;
                4'd11:   m = 8'h02;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/gcee_ctrl.sv]
// Controller for the gamepad change event encoder: idle/scan state machine.
// Depends on gcee_pkg.
`default_nettype none

module gcee_ctrl
    import gcee_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      sample_valid,
    output logic           sample_stall,
    input  wire gcee_sts_t sts,
    output gcee_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    assign sample_stall = (state_reg != ST_IDLE);
    assign cmd.load     = (state_reg == ST_IDLE) && sample_valid;
    assign cmd.step     = (state_reg == ST_SCAN) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && sts.has_events)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The scan ends once no pending position remains past this one.
                if (cmd.step && sts.rest_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && sts.rest_empty |=> state_reg == ST_IDLE)
        else $error("scan did not end after final position");

    a_quiet_sample: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && !sts.has_events |=> state_reg == ST_IDLE)
        else $error("sample without events started a scan");

    a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !cmd.load)
        else $error("sample loaded during a scan");
`endif

endmodule

`default_nettype wire

[rtl/core/gcee_dp.sv]
// Datapath for the gamepad change event encoder: sample history, pending
// change mask, scan counter, held-combo mask, config and the event register.
// Depends on gcee_pkg.
`default_nettype none

module gcee_dp
    import gcee_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [SAMPLE_W-1:0]   sample,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire gcee_cmd_t             cmd,
    output gcee_sts_t                  sts,
    output logic                       event_valid,
    input  wire logic                  event_stall,
    output logic                       pad,
    output logic [BUTTON_W-1:0]        button,
    output logic                       pressed,
    output logic                       pause,
    output logic                       last
);

    logic [SAMPLE_W-1:0]  prev_reg;
    logic [SAMPLE_W-1:0]  now_reg;
    logic [SCAN_LEN-1:0]  pending_reg;
    logic [SCAN_LEN-1:0]  pending_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [COMBO_W-1:0]   held_reg;
    logic [COMBO_W-1:0]   held_mid;
    logic [COMBO_W-1:0]   combo_reg;
    logic [PRESENT_W-1:0] present_reg;
    logic                 valid_reg;
    logic                 pad_reg;
    logic [BUTTON_W-1:0]  button_reg;
    logic                 pressed_reg;
    logic                 pause_reg;
    logic                 last_reg;

    logic [SAMPLE_W-1:0]  diff;
    logic [SCAN_LEN-1:0]  pending_in;
    logic [SCAN_LEN-1:0]  idx_mask;
    logic                 cur_pad;
    logic [BUTTON_W-1:0]  cur_button;
    logic [IDX_W-1:0]     bit_pos;
    logic                 cur_hit;
    logic                 cur_pressed;
    logic                 pause_hit;
    logic                 emit;

    // Changed button bits, laid out in scan order: pad 0 buttons, then pad 1.
    assign diff = sample ^ prev_reg;
    always_comb
    begin
        for (int p = 0; p < PADS; p++)
        begin
            for (int b = 0; b < BUTTONS_PER_PAD; b++)
            begin
                pending_in[p*BUTTONS_PER_PAD + b] =
                    diff[SAMPLE_W-1 - (2*b + p)] & present_reg[p];
            end
        end
    end

    assign idx_mask   = {{(SCAN_LEN-1){1'b0}}, 1'b1} << idx_reg;
    assign cur_pad    = (idx_reg >= IDX_W'(BUTTONS_PER_PAD));
    assign cur_button = cur_pad ? BUTTON_W'(idx_reg - IDX_W'(BUTTONS_PER_PAD))
                                : idx_reg[BUTTON_W-1:0];
    assign bit_pos    = IDX_W'(SAMPLE_W-1) - {cur_button, cur_pad};
    assign cur_hit    = |(pending_reg & idx_mask);
    assign cur_pressed = ~now_reg[bit_pos];
    assign emit       = cmd.step && cur_hit;

    always_comb
    begin
        held_mid = held_reg;
        if (!cur_pad)
        begin
            if (cur_pressed)
            begin
                held_mid = held_reg | combo_mask(cur_button);
            end
            else
            begin
                held_mid = held_reg & ~combo_mask(cur_button);
            end
        end
    end

    assign pause_hit = (combo_reg != '0) && ((held_mid & combo_reg) == combo_reg);

    assign pending_next = pending_reg & ~idx_mask;

    assign sts.has_events = |pending_in;
    assign sts.rest_empty = (pending_next == '0);
    assign sts.out_free   = !valid_reg || !event_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '1;
            held_reg    <= '0;
            pending_reg <= '0;
            idx_reg     <= '0;
            combo_reg   <= '0;
            present_reg <= '1;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_PAUSE_COMBO)
            begin
                combo_reg <= cfg_data[COMBO_W-1:0];
            end
            if (cfg_write && cfg_index == REG_PAD_PRESENT)
            begin
                present_reg <= cfg_data[PRESENT_W-1:0];
            end

            if (cmd.load)
            begin
                prev_reg    <= sample;
                pending_reg <= pending_in;
                idx_reg     <= '0;
            end
            else if (cmd.step)
            begin
                pending_reg <= pending_next;
                idx_reg     <= idx_reg + 1'b1;
            end

            if (emit)
            begin
                held_reg <= pause_hit ? '0 : held_mid;
            end

            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!event_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= sample;
        end
        if (emit)
        begin
            pad_reg     <= cur_pad;
            button_reg  <= cur_button;
            pressed_reg <= cur_pressed | pause_hit;
            pause_reg   <= pause_hit;
            last_reg    <= sts.rest_empty;
        end
    end

    assign event_valid = valid_reg;
    assign pad         = pad_reg;
    assign button      = button_reg;
    assign pressed     = pressed_reg;
    assign pause       = pause_reg;
    assign last        = last_reg;

`ifndef SYNTH
    a_pause_press: assert property (@(posedge clk) disable iff (!rst_n)
        emit && pause_hit |=> valid_reg && pressed_reg && held_reg == '0)
        else $error("pause event not a press or held mask not cleared");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> idx_reg == '0)
        else $error("scan counter not restarted on load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && event_stall |-> !emit)
        else $error("event register overwritten while stalled");
`endif

endmodule

`default_nettype wire

[rtl/core/gamepad_change_event_encoder_core.sv]
// Top level of the gamepad change event encoder: controller plus datapath.
// Depends on gcee_pkg, gcee_ctrl and gcee_dp.
//
//   Channel   Direction  Handshake                   Payload
//   sample    in         sample_valid/sample_stall   sample[31:0]
//   event     out        event_valid/event_stall     pad, button, pressed, pause, last
//   config    in         cfg_write                   cfg_index[1:0], cfg_data[7:0]
//
// A request is taken while the controller is idle. If it changes any button
// of a present pad, the scan counter then walks the button positions up to the
// last changed one, one per cycle while the event side does not stall. A sample
// with no reportable change leaves the controller idle for the next sample.
// A stalled event register holds the scan in place; the next sample is taken
// once the last position has been scanned, even while its event still waits.
// Reset (rst_n low, asynchronous) marks no buttons held and clears the combo.
`default_nettype none

module gamepad_change_event_encoder_core
    import gcee_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       event_valid,
    input  wire logic                  event_stall,
    output logic                       pad,
    output logic [BUTTON_W-1:0]        button,
    output logic                       pressed,
    output logic                       pause,
    output logic                       last,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    gcee_cmd_t cmd;
    gcee_sts_t sts;

    gcee_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    gcee_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .pad         (pad),
        .button      (button),
        .pressed     (pressed),
        .pause       (pause),
        .last        (last)
    );

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for gamepad_change_event_encoder_core.
// Predicts the press, release and pause events of each accepted sample and checks
// every event against them. Depends on gcee_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb
    import gcee_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1500;
    localparam int SETTLE_CYCLES  = SCAN_LEN + 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 25;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Held-combo bit of each pad-0 button, button 11 down to button 0.
    localparam logic [BUTTONS_PER_PAD*COMBO_W-1:0] HOLD_MASKS = {
        8'h02, 8'h01, 8'h10, 8'h04, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h80, 8'h40, 8'h20, 8'h08
    };

    typedef struct packed {
        logic                pad;
        logic [BUTTON_W-1:0] button;
        logic                pressed;
        logic                pause;
        logic                last;
    } pad_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    logic [SAMPLE_W-1:0]   sample;
    logic                  event_valid;
    logic                  event_stall;
    logic                  pad;
    logic [BUTTON_W-1:0]   button;
    logic                  pressed;
    logic                  pause;
    logic                  last;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Copy of the block's state and registers.
    logic [SAMPLE_W-1:0]  prev_word;
    logic [COMBO_W-1:0]   held_mask;
    logic [COMBO_W-1:0]   combo_cfg;
    logic [PRESENT_W-1:0] present_cfg;

    pad_event_t pending_events[$];
    pad_event_t head_event;
    int         err_count;
    int         quiet_cycles;
    int         hold_left;
    bit         hold_req;
    bit         tx_idle_en;
    bit         rx_idle_en;

    gamepad_change_event_encoder_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .pad          (pad),
        .button       (button),
        .pressed      (pressed),
        .pause        (pause),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the events of one accepted sample, in scan order.
    function automatic void predict_events(input logic [SAMPLE_W-1:0] word);
        logic [SAMPLE_W-1:0] changed;
        logic [COMBO_W-1:0]  bit_mask;
        pad_event_t          ev;
        logic                have_ev;
        int                  pos;
        changed = word ^ prev_word;
        have_ev = 1'b0;
        ev = '0;
        if (changed == '0)
            return;
        prev_word = word;
        for (int p = 0; p < PADS; p++)
        begin
            if (!present_cfg[p])
                continue;
            for (int b = 0; b < BUTTONS_PER_PAD; b++)
            begin
                pos = SAMPLE_W - 1 - (2 * b + p);
                if (!changed[pos])
                    continue;
                if (have_ev)
                    pending_events.push_back(ev);
                ev.pad     = p[0];
                ev.button  = b[BUTTON_W-1:0];
                ev.pressed = ~word[pos];
                ev.pause   = 1'b0;
                ev.last    = 1'b0;
                if (p == 0)
                begin
                    bit_mask = HOLD_MASKS[b*COMBO_W +: COMBO_W];
                    if (ev.pressed)
                        held_mask = held_mask | bit_mask;
                    else
                        held_mask = held_mask & ~bit_mask;
                end
                if (combo_cfg != '0 && (held_mask & combo_cfg) == combo_cfg)
                begin
                    ev.pause   = 1'b1;
                    ev.pressed = 1'b1;
                    held_mask  = '0;
                end
                have_ev = 1'b1;
            end
        end
        if (have_ev)
        begin
            ev.last = 1'b1;
            pending_events.push_back(ev);
        end
    endfunction

    // Mostly a few buttons changing, with some wholesale, repeated and low-byte words.
    function automatic logic [SAMPLE_W-1:0] random_word();
        logic [SAMPLE_W-1:0] w;
        int unsigned         r;
        int unsigned         k;
        r = $urandom_range(99);
        w = prev_word;
        if (r < 55)
        begin
            repeat ($urandom_range(3, 1))
            begin
                k = $urandom_range(SAMPLE_W - 1, 8);
                w[k] = ~w[k];
            end
        end
        else if (r < 70)
            w = prev_word ^ ($urandom & 32'hFFFF_FF00);
        else if (r < 82)
            w = $urandom;
        else if (r >= 92)
            w = prev_word ^ $urandom_range(255, 1);
        return w;
    endfunction

    function automatic logic [COMBO_W-1:0] random_combo();
        return (8'h01 << $urandom_range(7)) | (8'h01 << $urandom_range(7));
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] word);
        sample_valid <= 1'b1;
        sample       <= word;
        do
            @(posedge clk);
        while (sample_stall);
        predict_events(word);
        if (tx_idle_en && $urandom_range(99) < 32)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Stops offering requests and waits until the block has gone quiet.
    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_PAUSE_COMBO: combo_cfg = val[COMBO_W-1:0];
            REG_PAD_PRESENT: present_cfg = val[PRESENT_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [COMBO_W-1:0] combo, input logic [PRESENT_W-1:0] present);
        drain();
        write_reg(REG_PAUSE_COMBO, combo);
        write_reg(REG_PAD_PRESENT, CFG_DATA_W'(present));
    endtask

    task automatic test_scan_extremes();
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_00FF);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FF00);
        send_sample(32'hAAAA_AAAA);
        send_sample(32'h5555_5555);
        send_sample(32'hFFFF_FEFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_pad_present();
        // Only the low bits of the written value are kept.
        configure(8'h00, 2'b01);
        write_reg(REG_PAD_PRESENT, 8'hFD);
        send_sample(32'h0000_0000);
        configure(8'h00, 2'b10);
        send_sample(32'hFFFF_FFFF);
        configure(8'h00, 2'b00);
        send_sample(32'h1234_5678);
        drain();
        write_reg(REG_SPARE_A, 8'hA5);
        write_reg(REG_SPARE_B, 8'h5A);
        write_reg(REG_PAD_PRESENT, 8'h03);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_pause_combo();
        // L is held while the combo is disabled, so enabling it later lets a
        // pad-1 change complete the combo.
        configure(8'h00, 2'b11);
        send_sample(32'hFFFF_F7FF);
        configure(8'h01, 2'b11);
        send_sample(32'hFFBF_F7FF);
        send_sample(32'hFFBF_FFFF);
        send_sample(32'hFFBF_F7FF);
        configure(8'hFF, 2'b11);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h5555_55FF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
    endtask

    task automatic test_backpressure();
        configure(8'h00, 2'b11);
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (12)
            send_sample(~prev_word ^ ($urandom & 32'h0F0F_0F0F));
        drain();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random();
        logic [COMBO_W-1:0]   combo;
        logic [PRESENT_W-1:0] present;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       begin combo = 8'h00;          present = 2'b11; end
                2:       begin combo = 8'hFF;          present = 2'b01; end
                3:       begin combo = COMBO_W'($urandom_range(255, 1)); present = 2'b11; end
                5:       begin combo = random_combo(); present = PRESENT_W'($urandom_range(3)); end
                default: begin combo = random_combo(); present = 2'b11; end
            endcase
            configure(combo, present);
            tx_idle_en = (ph != 3);
            rx_idle_en = (ph != 3);
            repeat (PHASE_ITEMS)
                send_sample(random_word());
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '1;
        event_stall  <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_PAUSE_COMBO;
        cfg_data     <= '0;
        prev_word   = '1;
        held_mask   = '0;
        combo_cfg   = '0;
        present_cfg = 2'b11;
        err_count   = 0;
        hold_req    = 1'b0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scan_extremes();
        test_pad_present();
        test_pause_combo();
        test_backpressure();
        test_random();
        drain();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Event side: random stalls, or one long hold-off counted here.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left   = hold_left - 1;
            event_stall <= 1'b1;
        end
        else if (rx_idle_en)
            event_stall <= ($urandom_range(99) < 32);
        else
            event_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && event_valid && !event_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: pad %0d button %0d pressed %0d pause %0d last %0d",
                       pad, button, pressed, pause, last);
                err_count++;
            end
            else
            begin
                head_event = pending_events.pop_front();
                if (pad !== head_event.pad)
                begin
                    $error("pad: expected %0d, got %0d", head_event.pad, pad);
                    err_count++;
                end
                if (button !== head_event.button)
                begin
                    $error("button: expected %0d, got %0d", head_event.button, button);
                    err_count++;
                end
                if (pressed !== head_event.pressed)
                begin
                    $error("pressed: expected %0d, got %0d", head_event.pressed, pressed);
                    err_count++;
                end
                if (pause !== head_event.pause)
                begin
                    $error("pause: expected %0d, got %0d", head_event.pause, pause);
                    err_count++;
                end
                if (last !== head_event.last)
                begin
                    $error("last: expected %0d, got %0d", head_event.last, last);
                    err_count++;
                end
            end
        end
    end

    // Ends the run when no request moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (event_valid && !event_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

[filelist.f]
rtl/core/gcee_pkg.sv
rtl/core/gcee_ctrl.sv
rtl/core/gcee_dp.sv
rtl/core/gamepad_change_event_encoder_core.sv
bench/tb.sv
